// File: design/asrfd_pkg.sv
package asrfd_pkg;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_MIN_LEVEL    = 3'd0,
    REG_MAX_LEVEL    = 3'd1,
    REG_MIN_DURATION = 3'd2,
    REG_MAX_DURATION = 3'd3,
    REG_TIMEOUT      = 3'd4,
    REG_CEILING      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic [15:0] min_duration_ms;
    logic [15:0] max_duration_ms;
    logic [15:0] level_hold_ms;
    logic [7:0]  matrix_ceiling;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CAPTURE,
    DP_SMOOTH,
    DP_SET_TARGET,
    DP_SET_LENGTH,
    DP_SQUARE,
    DP_CUBE,
    DP_PULSE,
    DP_DUTY,
    DP_MATRIX,
    DP_LOAD_OUT
  } dp_op_e;

  // Divider jobs: operand selection for a divider start
  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_TARGET,
    DIV_LENGTH,
    DIV_EASE
  } div_op_e;

  typedef struct packed {
    dp_op_e  op;
    div_op_e div;
  } ctrl_cmd_t;

  typedef struct packed {
    logic renew;
    logic div_busy;
  } ctrl_stat_t;

endpackage

// File: design/asrfd_ifs.sv
interface asrfd_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        level_valid;
  logic [7:0]  new_level;
  logic [15:0] rand_target;
  logic [15:0] rand_duration;

  modport source (
    output valid, now_ms, level_valid, new_level, rand_target, rand_duration,
    input  ready
  );
  modport sink (
    input  valid, now_ms, level_valid, new_level, rand_target, rand_duration,
    output ready
  );
endinterface

interface asrfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] light_duty;
  logic [7:0] matrix_brightness;

  modport source (
    output valid, light_duty, matrix_brightness,
    input  ready
  );
  modport sink (
    input  valid, light_duty, matrix_brightness,
    output ready
  );
endinterface

// File: design/asrfd_regs.sv
module asrfd_regs
  import asrfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level        <= 8'd0;
      cfg_q.max_level        <= 8'd255;
      cfg_q.min_duration_ms  <= 16'd600;
      cfg_q.max_duration_ms  <= 16'd2500;
      cfg_q.level_hold_ms    <= 16'd1500;
      cfg_q.matrix_ceiling   <= 8'd90;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_LEVEL:    cfg_q.min_level        <= pwdata[7:0];
        REG_MAX_LEVEL:    cfg_q.max_level        <= pwdata[7:0];
        REG_MIN_DURATION: cfg_q.min_duration_ms  <= pwdata[15:0];
        REG_MAX_DURATION: cfg_q.max_duration_ms  <= pwdata[15:0];
        REG_TIMEOUT:      cfg_q.level_hold_ms    <= pwdata[15:0];
        REG_CEILING:      cfg_q.matrix_ceiling   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      REG_MIN_LEVEL:    prdata = {24'd0, cfg_q.min_level};
      REG_MAX_LEVEL:    prdata = {24'd0, cfg_q.max_level};
      REG_MIN_DURATION: prdata = {16'd0, cfg_q.min_duration_ms};
      REG_MAX_DURATION: prdata = {16'd0, cfg_q.max_duration_ms};
      REG_TIMEOUT:      prdata = {16'd0, cfg_q.level_hold_ms};
      REG_CEILING:      prdata = {24'd0, cfg_q.matrix_ceiling};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: design/asrfd_div.sv
module asrfd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] rem_i,
  input  logic [15:0] num_i,
  input  logic [16:0] den_i,
  output logic        busy_o,
  output logic [15:0] quo_o,
  output logic [16:0] rem_o
);

  localparam int Steps = 16;

  logic [4:0]  cnt_q;
  logic [16:0] rem_q;
  logic [15:0] num_q;
  logic [16:0] den_q;
  logic [17:0] trial;
  logic        ge;

  // Restoring step: shift in one dividend bit, subtract when it fits
  assign trial  = {rem_q, num_q[15]};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = (cnt_q != 5'd0);
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= 5'(Steps);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_o) begin
      rem_q <= ge ? 17'(trial - {1'b0, den_q}) : trial[16:0];
      num_q <= {num_q[14:0], ge};
    end
  end

endmodule

// File: design/asrfd_dp.sv
module asrfd_dp
  import asrfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_stat_t  stat_o,
  input  logic [31:0] now_ms_i,
  input  logic        level_valid_i,
  input  logic [7:0]  new_level_i,
  input  logic [15:0] rand_target_i,
  input  logic [15:0] rand_duration_i,
  output logic [7:0]  light_duty_o,
  output logic [7:0]  matrix_brightness_o
);

  localparam logic [13:0] AlphaQ16   = 14'd13107;
  localparam logic [17:0] EaseBias   = 18'd196608;
  localparam logic [7:0]  LevelFull  = 8'd255;

  // x / 255 for x below 65535
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[16:8];
  endfunction

  // Persistent state
  logic [7:0]  held_q;
  logic [31:0] held_time_q;
  logic        seen_q;
  logic [15:0] smooth_q;
  logic [7:0]  start_q;
  logic [7:0]  target_q;
  logic [31:0] seg_start_q;
  logic [15:0] seg_len_q;

  // Per-item work registers
  logic [31:0] now_q;
  logic [15:0] rt_q;
  logic [15:0] rd_q;
  logic [15:0] t2_q;
  logic [17:0] coef_q;
  logic [15:0] e_q;
  logic [7:0]  pulse_q;
  logic [7:0]  duty_q;
  logic [7:0]  mat_q;
  logic [7:0]  out_duty_q;
  logic [7:0]  out_mat_q;

  // Divider
  logic        div_start;
  logic [16:0] div_rem0;
  logic [15:0] div_num;
  logic [16:0] div_den;
  logic        div_busy;
  logic [15:0] div_quo;
  logic [16:0] div_rem;

  logic [31:0] elapsed;
  logic [8:0]  lvl_span;
  logic [16:0] dur_span;

  // Level smoothing
  logic [31:0] level_age;
  logic [7:0]  level_tgt;
  logic [15:0] level_tgt16;
  logic        rising;
  logic [15:0] gap;
  logic [29:0] gap_prod;
  logic [30:0] gap_round;
  logic [14:0] mag;
  logic [15:0] smooth_d;

  // Segment renewal
  logic [7:0]  target_d;
  logic [15:0] len_sel;
  logic [15:0] len_d;

  // Easing and output math
  logic [31:0] t_sq;
  logic [33:0] cube_prod;
  logic [17:0] e_wide;
  logic signed [8:0]  step;
  logic signed [25:0] step_prod;
  logic signed [26:0] acc;
  logic [7:0]  pulse_d;
  logic [23:0] duty_prod;
  logic [8:0]  duty_div;
  logic [15:0] mat_prod;
  logic [8:0]  mat_div;

  assign elapsed  = now_q - seg_start_q;
  assign lvl_span = {1'b0, cfg_i.max_level} - {1'b0, cfg_i.min_level} + 9'd1;
  assign dur_span = {1'b0, cfg_i.max_duration_ms} - {1'b0, cfg_i.min_duration_ms} + 17'd1;

  assign stat_o.renew    = (elapsed >= {16'd0, seg_len_q});
  assign stat_o.div_busy = div_busy;

  always_comb begin
    div_start = (cmd_i.div != DIV_NONE);
    div_rem0  = 17'd0;
    div_num   = 16'd0;
    div_den   = 17'd1;
    case (cmd_i.div)
      DIV_TARGET: begin
        div_num = rt_q;
        div_den = {8'd0, lvl_span};
      end
      DIV_LENGTH: begin
        div_num = rd_q;
        div_den = dur_span;
      end
      DIV_EASE: begin
        div_rem0 = {1'b0, elapsed[15:0]};
        div_den  = {1'b0, seg_len_q};
      end
      default: ;
    endcase
  end

  asrfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem0),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // EMA toward the current level target, rounding the step away from zero
  always_comb begin
    level_age   = now_q - held_time_q;
    level_tgt   = (seen_q && (level_age < {16'd0, cfg_i.level_hold_ms})) ? held_q
                                                                      : LevelFull;
    level_tgt16 = {level_tgt, 8'd0};
    rising      = (level_tgt16 >= smooth_q);
    gap         = rising ? (level_tgt16 - smooth_q) : (smooth_q - level_tgt16);
    gap_prod    = gap * AlphaQ16;
    gap_round   = {1'b0, gap_prod} + 31'd65535;
    mag         = gap_round[30:16];
    smooth_d    = rising ? (smooth_q + {1'b0, mag}) : (smooth_q - {1'b0, mag});
  end

  always_comb begin
    target_d = (cfg_i.max_level <= cfg_i.min_level) ? cfg_i.min_level
                                                    : (cfg_i.min_level + div_rem[7:0]);
    len_sel  = (cfg_i.max_duration_ms <= cfg_i.min_duration_ms)
               ? cfg_i.min_duration_ms : (cfg_i.min_duration_ms + div_rem[15:0]);
    len_d    = (len_sel == 16'd0) ? 16'd1 : len_sel;
  end

  always_comb begin
    t_sq      = div_quo * div_quo;
    cube_prod = t2_q * coef_q;
    e_wide    = cube_prod[33:16];
    step      = $signed({1'b0, target_q}) - $signed({1'b0, start_q});
    step_prod = step * $signed({1'b0, e_q});
    acc       = $signed({3'b000, start_q, 16'h0000}) + {step_prod[25], step_prod};
    if (acc[26]) begin
      pulse_d = 8'd0;
    end else if (acc[25:24] != 2'b00) begin
      pulse_d = 8'd255;
    end else begin
      pulse_d = acc[23:16];
    end
    duty_prod = pulse_q * smooth_q;
    duty_div  = div255(duty_prod[23:8]);
    mat_prod  = duty_q * cfg_i.matrix_ceiling;
    mat_div   = div255(mat_prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= LevelFull;
      held_time_q <= 32'd0;
      seen_q      <= 1'b0;
      smooth_q    <= 16'hFF00;
      start_q     <= 8'd0;
      target_q    <= 8'd0;
      seg_start_q <= 32'd0;
      seg_len_q   <= 16'd1;
    end else begin
      case (cmd_i.op)
        DP_CAPTURE: begin
          if (level_valid_i) begin
            held_q      <= new_level_i;
            held_time_q <= now_ms_i;
            seen_q      <= 1'b1;
          end
        end
        DP_SMOOTH: smooth_q <= smooth_d;
        DP_SET_TARGET: begin
          start_q  <= target_q;
          target_q <= target_d;
        end
        DP_SET_LENGTH: begin
          seg_len_q   <= len_d;
          seg_start_q <= now_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_CAPTURE: begin
        now_q <= now_ms_i;
        rt_q  <= rand_target_i;
        rd_q  <= rand_duration_i;
      end
      DP_SQUARE: begin
        t2_q   <= t_sq[31:16];
        coef_q <= EaseBias - {1'b0, div_quo, 1'b0};
      end
      DP_CUBE:   e_q     <= (e_wide[17:16] != 2'b00) ? 16'hFFFF : e_wide[15:0];
      DP_PULSE:  pulse_q <= pulse_d;
      DP_DUTY:   duty_q  <= duty_div[8] ? 8'd255 : duty_div[7:0];
      DP_MATRIX: mat_q   <= mat_div[7:0];
      DP_LOAD_OUT: begin
        out_duty_q <= duty_q;
        out_mat_q  <= mat_q;
      end
      default: ;
    endcase
  end

  assign light_duty_o        = out_duty_q;
  assign matrix_brightness_o = out_mat_q;

endmodule

// File: design/asrfd_ctrl.sv
module asrfd_ctrl
  import asrfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMOOTH,
    S_TARGET,
    S_LENGTH,
    S_EASE_GO,
    S_EASE,
    S_CUBE,
    S_PULSE,
    S_DUTY,
    S_MATRIX,
    S_DELIVER
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = DP_IDLE;
    cmd_o.div   = DIV_NONE;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_CAPTURE;
          state_d  = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd_o.op = DP_SMOOTH;
        if (stat_i.renew) begin
          cmd_o.div = DIV_TARGET;
          state_d   = S_TARGET;
        end else begin
          cmd_o.div = DIV_EASE;
          state_d   = S_EASE;
        end
      end
      S_TARGET: begin
        if (!stat_i.div_busy) begin
          cmd_o.op  = DP_SET_TARGET;
          cmd_o.div = DIV_LENGTH;
          state_d   = S_LENGTH;
        end
      end
      S_LENGTH: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = DP_SET_LENGTH;
          state_d  = S_EASE_GO;
        end
      end
      S_EASE_GO: begin
        cmd_o.div = DIV_EASE;
        state_d   = S_EASE;
      end
      S_EASE: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = DP_SQUARE;
          state_d  = S_CUBE;
        end
      end
      S_CUBE: begin
        cmd_o.op = DP_CUBE;
        state_d  = S_PULSE;
      end
      S_PULSE: begin
        cmd_o.op = DP_PULSE;
        state_d  = S_DUTY;
      end
      S_DUTY: begin
        cmd_o.op = DP_DUTY;
        state_d  = S_MATRIX;
      end
      S_MATRIX: begin
        cmd_o.op = DP_MATRIX;
        state_d  = S_DELIVER;
      end
      S_DELIVER: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/audio_scaled_random_fade_dimmer_top.sv
// Channel   Dir  Handshake          Payload
// tick_i    in   valid/ready        now_ms, level_valid, new_level, rand_target, rand_duration
// result_o  out  valid/ready        light_duty, matrix_brightness
// apb       in   psel/penable/pwrite  paddr[4:2] selects register, pwdata, prdata
//
// One item at a time: the next item is accepted only once the last is in the output
// register. The 16-step restoring divider runs once per item for the ease fraction,
// and twice more for the new target and length draws when the segment renews.
// Reset: async, active low; returns config, segment and level state to defaults.
// The output register frees the core: a stalled result blocks only the final load.
module audio_scaled_random_fade_dimmer_top
  import asrfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  asrfd_tick_if.sink            tick_i,
  asrfd_result_if.source        result_o
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] light_duty;
  logic [7:0] matrix_brightness;

  // Configuration registers
  asrfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: steps each item through smoothing, draws, easing and scaling
  asrfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: fade state, level EMA, shared divider, multipliers, output register
  asrfd_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .now_ms_i            (tick_i.now_ms),
    .level_valid_i       (tick_i.level_valid),
    .new_level_i         (tick_i.new_level),
    .rand_target_i       (tick_i.rand_target),
    .rand_duration_i     (tick_i.rand_duration),
    .light_duty_o        (light_duty),
    .matrix_brightness_o (matrix_brightness)
  );

  assign tick_i.ready               = in_ready;
  assign result_o.valid             = out_valid;
  assign result_o.light_duty        = light_duty;
  assign result_o.matrix_brightness = matrix_brightness;

endmodule

// File: sim/tb_audio_scaled_random_fade_dimmer_top.sv
`timescale 1ns / 100ps

module tb_audio_scaled_random_fade_dimmer_top
  import asrfd_pkg::*;
();

  // Long receiver hold-off, and the number of quiet cycles that counts as a hang.
  // The hang limit covers the slowest item plus the hold-off and the APB phases.
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int HANG_LIMIT       = 4000;
  localparam int DRAIN_CYCLES     = 64;
  localparam int EMA_ALPHA_Q16    = 13107;
  localparam int FULL_SCALE_Q88   = 65280;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        level_valid;
    logic [7:0]  new_level;
    logic [15:0] rand_target;
    logic [15:0] rand_duration;
  } tick_t;

  typedef struct packed {
    logic [7:0] light_duty;
    logic [7:0] matrix_brightness;
  } dimmer_out_t;

  // One directed row: the tick, and where the outcome is obvious, its typed-in result.
  typedef struct packed {
    tick_t       tick;
    logic        typed;
    dimmer_out_t want;
  } directed_row_t;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_e;

  // Directed ticks, all under reset configuration (levels 0..255, 600..2500 ms,
  // timeout 1500 ms, ceiling 90).
  localparam directed_row_t DIRECTED [20] = '{
    // segment still open at reset: pulse holds at the zero start level
    '{'{32'h0000_0000, 1'b0, 8'h00, 16'h0000, 16'h0000}, 1'b1, '{8'd0, 8'd0}},
    // first renewal: target 255 over 600 ms, pulse starts from zero
    '{'{32'h0000_0001, 1'b0, 8'h00, 16'h00FF, 16'h0000}, 1'b1, '{8'd0, 8'd0}},
    // renewal from 255 to 255: full duty, matrix at its ceiling
    '{'{32'd601,       1'b0, 8'h00, 16'hFFFF, 16'd1900}, 1'b1, '{8'd255, 8'd90}},
    // silence arrives: one EMA step from 255.0 down to 204.0
    '{'{32'd1851,      1'b1, 8'h00, 16'h0000, 16'h0000}, 1'b1, '{8'd204, 8'd72}},
    '{'{32'd1852,      1'b1, 8'hFF, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{32'd1900,      1'b1, 8'hAA, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{32'd2000,      1'b1, 8'h55, 16'h0000, 16'h0000}, 1'b0, '0},
    // level one ms short of its timeout, then exactly at it
    '{'{32'd3499,      1'b0, 8'h00, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{32'd3500,      1'b0, 8'h00, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{32'd3501,      1'b1, 8'h00, 16'h0000, 16'hFFFF}, 1'b0, '0},
    // top of the time range, a forward wrap, then time running backwards
    '{'{32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{32'h0000_0010, 1'b0, 8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{32'h0000_0005, 1'b0, 8'h00, 16'h1234, 16'h4321}, 1'b0, '0},
    '{'{32'h8000_0000, 1'b1, 8'h01, 16'h00FE, 16'h0001}, 1'b0, '0},
    // second level at the same ms, zero elapsed time
    '{'{32'h8000_0000, 1'b1, 8'hFE, 16'h0001, 16'h00FE}, 1'b0, '0},
    '{'{32'h8000_0123, 1'b0, 8'h00, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{32'h7FFF_FFFF, 1'b0, 8'h00, 16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{32'h5555_5555, 1'b1, 8'hAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{32'hAAAA_AAAA, 1'b1, 8'h55, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{32'hAAAA_AAAB, 1'b0, 8'h00, 16'h0000, 16'h0000}, 1'b0, '0}
  };

  // Configuration sets for the random phases, field order as in cfg_t:
  // min/max level, min/max duration, timeout, matrix ceiling.
  localparam int NUM_PHASES = 6;
  localparam cfg_t FADE_PHASES [NUM_PHASES] = '{
    '{8'd0,   8'd255, 16'd1,     16'd40,    16'd25,    8'd255},
    '{8'd255, 8'd255, 16'd65535, 16'd65535, 16'd65535, 8'd0},
    '{8'd200, 8'd10,  16'd50,    16'd5,     16'd1,     8'd128},
    '{8'd17,  8'd230, 16'd1,     16'd1,     16'd3000,  8'd90},
    '{8'd0,   8'd255, 16'd100,   16'd65535, 16'd200,   8'd255},
    '{8'h55,  8'hAA,  16'd3,     16'd170,   16'd700,   8'd200}
  };
  localparam int PHASE_ITEMS [NUM_PHASES] = '{180, 60, 120, 120, 130, 115};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  asrfd_tick_if   tick_ch ();
  asrfd_result_if result_ch ();

  audio_scaled_random_fade_dimmer_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .tick_i   (tick_ch),
    .result_o (result_ch)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block: configuration, fade segment and audio level.
  cfg_t        cfg_model = '{8'd0, 8'd255, 16'd600, 16'd2500, 16'd1500, 8'd90};
  logic [7:0]  fade_start    = 8'd0;
  logic [7:0]  fade_target   = 8'd0;
  logic [31:0] seg_start     = 32'd0;
  logic [15:0] seg_len       = 16'd1;
  logic [7:0]  held_level    = 8'd255;
  logic [31:0] held_time     = 32'd0;
  logic        level_seen    = 1'b0;
  logic [15:0] smoothed_q88  = 16'hFF00;

  dimmer_out_t pending_outputs [$];
  int          fail_count   = 0;
  int          quiet_cycles = 0;
  bit          long_hold_req = 1'b0;
  logic [31:0] sim_now      = 32'd0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // min plus word modulo span; an empty or inverted range yields min
  function automatic int unsigned draw_in_range(int unsigned lo, int unsigned hi,
                                                int unsigned word);
    if (hi <= lo) return lo;
    return lo + word % (hi - lo + 1);
  endfunction

  // Smoothstep 3t^2 - 2t^3 with t = elapsed/len, all in Q0.16
  function automatic int unsigned smoothstep_q16(int unsigned elapsed, int unsigned len);
    longint unsigned el64, frac, sq, e;
    el64 = elapsed;
    frac = (el64 << 16) / len;
    if (frac > 65535) frac = 65535;
    sq = (frac * frac) >> 16;
    e  = (sq * (64'd196608 - 2 * frac)) >> 16;
    if (e > 65535) e = 65535;
    return e[31:0];
  endfunction

  function automatic dimmer_out_t predict_dimmer_tick(tick_t t);
    logic [31:0] age, elapsed;
    int unsigned lvl, ease_q16, pulse, duty;
    longint      diff, acc, step;
    dimmer_out_t r;
    // latch a fresh level before judging its age
    if (t.level_valid) begin
      held_level = t.new_level;
      held_time  = t.now_ms;
      level_seen = 1'b1;
    end
    age = t.now_ms - held_time;
    lvl = (level_seen && age < {16'd0, cfg_model.level_hold_ms}) ? held_level : 255;

    // EMA toward lvl, step rounded away from zero so it lands exactly
    diff = longint'(lvl) * 256 - longint'(smoothed_q88);
    if (diff >= 0) begin
      step = (diff * EMA_ALPHA_Q16 + 65535) >>> 16;
      smoothed_q88 = smoothed_q88 + step[15:0];
    end else begin
      step = (-diff * EMA_ALPHA_Q16 + 65535) >>> 16;
      smoothed_q88 = smoothed_q88 - step[15:0];
    end

    elapsed = t.now_ms - seg_start;
    if (elapsed >= {16'd0, seg_len}) begin
      fade_start  = fade_target;
      fade_target = 8'(draw_in_range(cfg_model.min_level, cfg_model.max_level,
                                     t.rand_target));
      seg_len     = 16'(draw_in_range(cfg_model.min_duration_ms,
                                      cfg_model.max_duration_ms, t.rand_duration));
      if (seg_len == 16'd0) seg_len = 16'd1;
      seg_start = t.now_ms;
      elapsed   = 32'd0;
    end

    ease_q16 = smoothstep_q16(elapsed, seg_len);
    acc = longint'(fade_start) * 65536
        + (longint'(fade_target) - longint'(fade_start)) * longint'(ease_q16);
    if (acc < 0) acc = 0;
    pulse = 32'(acc >>> 16);
    if (pulse > 255) pulse = 255;

    duty = (pulse * smoothed_q88) / FULL_SCALE_Q88;
    if (duty > 255) duty = 255;
    r.light_duty        = 8'(duty);
    r.matrix_brightness = 8'(duty * cfg_model.matrix_ceiling / 255);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random tick source
  // ---------------------------------------------------------------------------

  // Advance time mostly in steps on the scale of the segment length, with hits on
  // the exact segment edge, level timeouts, zero steps, far jumps and time going back.
  function automatic tick_t make_random_tick();
    int unsigned hint, roll;
    tick_t       t;
    hint = (cfg_model.max_duration_ms > cfg_model.min_duration_ms) ?
           cfg_model.max_duration_ms : cfg_model.min_duration_ms;
    roll = $urandom_range(0, 99);
    if (roll < 55)      sim_now = sim_now + $urandom_range(0, hint / 3 + 1);
    else if (roll < 70) sim_now = sim_now + $urandom_range(0, cfg_model.level_hold_ms + 2);
    else if (roll < 80) sim_now = sim_now;
    else if (roll < 88) sim_now = sim_now + hint - 1 + $urandom_range(0, 2);
    else if (roll < 94) sim_now = $urandom();
    else                sim_now = sim_now - $urandom_range(1, 3000);
    t.now_ms      = sim_now;
    t.level_valid = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 9);
    t.new_level     = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom());
    t.rand_target   = 16'($urandom());
    t.rand_duration = 16'($urandom());
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drop valid and scramble the payload so idle data is ignored.
  task automatic idle_ticks(int n);
    repeat (n) begin
      @(negedge clk_i);
      tick_ch.valid         <= 1'b0;
      tick_ch.now_ms        <= $urandom();
      tick_ch.level_valid   <= 1'($urandom());
      tick_ch.new_level     <= 8'($urandom());
      tick_ch.rand_target   <= 16'($urandom());
      tick_ch.rand_duration <= 16'($urandom());
    end
  endtask

  // Offer one item and hold it until accepted, then record what it must produce.
  task automatic send_tick(tick_t t, logic typed, dimmer_out_t typed_want);
    dimmer_out_t predicted;
    @(negedge clk_i);
    tick_ch.valid         <= 1'b1;
    tick_ch.now_ms        <= t.now_ms;
    tick_ch.level_valid   <= t.level_valid;
    tick_ch.new_level     <= t.new_level;
    tick_ch.rand_target   <= t.rand_target;
    tick_ch.rand_duration <= t.rand_duration;
    do @(posedge clk_i); while (tick_ch.ready !== 1'b1);
    predicted = predict_dimmer_tick(t);
    pending_outputs.push_back(typed ? typed_want : predicted);
  endtask

  // Stop offering and wait until every outstanding result is back.
  task automatic drain();
    idle_ticks(1);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Burst/gap pattern: bursts of 1..24 items separated by idle gaps, and about
  // one burst in four runs straight into the next with no gap at all.
  task automatic run_random(int count);
    int burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_ticks($urandom_range(1, 12));
        burst = $urandom_range(1, 24);
      end
      burst--;
      send_tick(make_random_tick(), 1'b0, '0);
    end
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic apb_write(reg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_MIN_LEVEL:    cfg_model.min_level        = data[7:0];
      REG_MAX_LEVEL:    cfg_model.max_level        = data[7:0];
      REG_MIN_DURATION: cfg_model.min_duration_ms  = data[15:0];
      REG_MAX_DURATION: cfg_model.max_duration_ms  = data[15:0];
      REG_TIMEOUT:      cfg_model.level_hold_ms    = data[15:0];
      REG_CEILING:      cfg_model.matrix_ceiling   = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    dimmer_out_t want, got;
    if (rst_ni && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.light_duty        = result_ch.light_duty;
      got.matrix_brightness = result_ch.matrix_brightness;
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("result with nothing expected: duty %0d matrix %0d",
                               got.light_duty, got.matrix_brightness));
      end else begin
        want = pending_outputs.pop_front();
        if (got.light_duty !== want.light_duty ||
            got.matrix_brightness !== want.matrix_brightness) begin
          note_failure($sformatf("mismatch: duty exp %0d got %0d, matrix exp %0d got %0d",
                                 want.light_duty, got.light_duty,
                                 want.matrix_brightness, got.matrix_brightness));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hang detector: count cycles with no handshake on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni ||
        (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: switch between randomly chosen stall patterns, and
  // serve a long hold-off when the stimulus asks for one.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    result_ch.ready = 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        // hold ready low long enough for the core and the output register to fill
        long_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 4));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:     result_ch.ready <= 1'b1;
          SINK_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY:   result_ch.ready <= ($urandom_range(0, 9) != 0);
          SINK_PERIODIC: result_ch.ready <= (mode_left % 3 != 0);
          default:       result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t c;
    // drive every input to a known value before reset releases
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.now_ms        = '0;
    tick_ch.level_valid   = 1'b0;
    tick_ch.new_level     = '0;
    tick_ch.rand_target   = '0;
    tick_ch.rand_duration = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows under the reset configuration
    foreach (DIRECTED[i]) send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // reconfigure only with the block empty
      drain();
      c = FADE_PHASES[p];
      apb_write(REG_MIN_LEVEL,    {24'd0, c.min_level});
      apb_write(REG_MAX_LEVEL,    {24'd0, c.max_level});
      apb_write(REG_MIN_DURATION, {16'd0, c.min_duration_ms});
      apb_write(REG_MAX_DURATION, {16'd0, c.max_duration_ms});
      apb_write(REG_TIMEOUT,      {16'd0, c.level_hold_ms});
      apb_write(REG_CEILING,      {24'd0, c.matrix_ceiling});
      sim_now = $urandom();

      if (p == 0) begin
        run_random(60);
        // back up the result side while items keep coming back to back
        long_hold_req = 1'b1;
        repeat (12) send_tick(make_random_tick(), 1'b0, '0);
        run_random(PHASE_ITEMS[p] - 72);
      end else if (p == 2) begin
        run_random(PHASE_ITEMS[p] / 2);
        // pause the sender until everything outstanding has come back
        drain();
        run_random(PHASE_ITEMS[p] - PHASE_ITEMS[p] / 2);
      end else begin
        run_random(PHASE_ITEMS[p]);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
